[design/tbuart_pkg.sv]
// shared types and constants for the timer based uart transmitter and receiver
package tbuart_pkg;

    // field widths
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned TX_CNT_W   = 16;
    localparam int unsigned RX_CNT_W   = 17;
    localparam int unsigned BITS_W     = 4;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned FRAME_W    = 10;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 16;

    // frame and reset constants
    localparam logic [BITS_W-1:0]   TX_FRAME_BITS    = 4'd10;
    localparam logic [BITS_W-1:0]   RX_DATA_BITS     = 4'd8;
    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd104;

    // one input transfer, last field in the lowest bits
    typedef struct packed {
        logic [5:0]        pad;
        logic [BYTE_W-1:0] send_byte;
        logic              send_request;
        logic              rx_line;
    } in_item_t;

    // one result transfer, last field in the lowest bits
    typedef struct packed {
        logic [3:0]        pad;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_valid;
        logic              send_accepted;
        logic              tx_busy;
        logic              tx_line;
    } out_item_t;

endpackage

[design/timer_based_uart_tx_rx_top.sv]
// uart 8n1 transmitter and receiver stepped by one input transfer per tick
//
//  channel | ports                          | contents (low bit first)
//  --------+--------------------------------+-----------------------------------------------
//  in      | s_axis_tvalid/tready/tdata[15:0] | rx_line, send_request, send_byte[7:0], zero pad
//  out     | m_axis_tvalid/tready/tdata[15:0] | tx_line, tx_busy, send_accepted, rx_valid,
//          |                                | rx_byte[7:0], zero pad
//  cfg     | cfg_we, cfg_wdata[15:0]        | bit_period
//
// one transfer is taken every cycle while the input is open; its result is registered and
// leaves from the output register. a two entry output buffer (output register plus skid
// register) keeps the input open while one result waits; the input stalls only when both
// are full. all timing state advances only on an input transfer. reset is
// synchronous, active low, and loads bit_period with 104.
module timer_based_uart_tx_rx_top
    import tbuart_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [PERIOD_W-1:0]  cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [0] rx_line, [1] send_request, [9:2] send_byte, [15:10] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] tx_line, [1] tx_busy, [2] send_accepted, [3] rx_valid, [11:4] rx_byte, [15:12] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // configuration
    logic [PERIOD_W-1:0] bit_period_reg;

    // transmitter state
    logic [FRAME_W-1:0]  tx_shift_reg,      tx_shift_next;
    logic [BITS_W-1:0]   tx_bits_left_reg,  tx_bits_left_next;
    logic [TX_CNT_W-1:0] tx_tick_count_reg, tx_tick_count_next;
    logic                tx_active_reg,     tx_active_next;
    logic                tx_level_reg,      tx_level_next;
    logic                tx_pending_reg,    tx_pending_next;

    // receiver state
    logic                rx_hunting_reg,    rx_hunting_next;
    logic [RX_CNT_W-1:0] rx_tick_count_reg, rx_tick_count_next;
    logic [BYTE_W-1:0]   rx_shift_reg,      rx_shift_next;
    logic [BITS_W-1:0]   rx_bits_left_reg,  rx_bits_left_next;
    logic                rx_prev_level_reg;
    logic [BYTE_W-1:0]   rx_held_byte_reg,  rx_held_byte_next;

    // output buffer
    out_item_t           out_item_reg, skid_item_reg, result_next;
    logic                out_valid_reg, skid_valid_reg;

    in_item_t            in_item;
    logic                in_fire, out_fire;
    logic [PERIOD_W-1:0] period;
    logic [RX_CNT_W-1:0] rx_target;
    logic [TX_CNT_W-1:0] tx_tick_inc;
    logic [RX_CNT_W-1:0] rx_tick_inc;
    logic                accepted_next, rx_valid_next;

    assign in_item       = in_item_t'(s_axis_tdata);
    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_item_reg);

    // effective bit period, zero acts as one
    assign period    = (bit_period_reg == '0) ? PERIOD_W'(1) : bit_period_reg;
    assign rx_target = {1'b0, period} + {2'b00, period[PERIOD_W-1:1]};
    assign tx_tick_inc = tx_tick_count_reg + TX_CNT_W'(1);
    assign rx_tick_inc = rx_tick_count_reg + RX_CNT_W'(1);

    // transmitter next state
    always_comb begin
        tx_shift_next      = tx_shift_reg;
        tx_bits_left_next  = tx_bits_left_reg;
        tx_tick_count_next = tx_tick_count_reg;
        tx_active_next     = tx_active_reg;
        tx_level_next      = tx_level_reg;
        tx_pending_next    = tx_pending_reg;
        accepted_next      = 1'b0;
        if (tx_active_reg) begin
            tx_tick_count_next = tx_tick_inc;
            if (tx_tick_inc >= period) begin
                // bit boundary: line takes the pending level
                tx_tick_count_next = '0;
                tx_level_next      = tx_pending_reg;
                if (tx_bits_left_reg == '0) begin
                    tx_active_next    = 1'b0;
                    tx_bits_left_next = TX_FRAME_BITS;
                end else begin
                    tx_pending_next   = tx_shift_reg[0];
                    tx_shift_next     = {1'b1, tx_shift_reg[FRAME_W-1:1]};
                    tx_bits_left_next = tx_bits_left_reg - BITS_W'(1);
                end
            end
        end else if (in_item.send_request) begin
            // load stop bit, data and start bit
            tx_shift_next      = {1'b1, in_item.send_byte, 1'b0};
            tx_bits_left_next  = TX_FRAME_BITS;
            tx_tick_count_next = '0;
            tx_pending_next    = 1'b1;
            tx_active_next     = 1'b1;
            accepted_next      = 1'b1;
        end
    end

    // receiver next state
    always_comb begin
        rx_hunting_next    = rx_hunting_reg;
        rx_tick_count_next = rx_tick_count_reg;
        rx_shift_next      = rx_shift_reg;
        rx_bits_left_next  = rx_bits_left_reg;
        rx_held_byte_next  = rx_held_byte_reg;
        rx_valid_next      = 1'b0;
        if (rx_hunting_reg) begin
            // falling edge starts a frame
            if (rx_prev_level_reg && !in_item.rx_line) begin
                rx_hunting_next    = 1'b0;
                rx_tick_count_next = '0;
                rx_bits_left_next  = RX_DATA_BITS;
            end
        end else begin
            rx_tick_count_next = rx_tick_inc;
            if (rx_tick_inc >= ((rx_bits_left_reg >= RX_DATA_BITS) ? rx_target
                                                                   : {1'b0, period})) begin
                rx_tick_count_next = '0;
                rx_shift_next      = {in_item.rx_line, rx_shift_reg[BYTE_W-1:1]};
                rx_bits_left_next  = rx_bits_left_reg - BITS_W'(1);
                if (rx_bits_left_reg == BITS_W'(1)) begin
                    rx_held_byte_next = {in_item.rx_line, rx_shift_reg[BYTE_W-1:1]};
                    rx_bits_left_next = RX_DATA_BITS;
                    rx_hunting_next   = 1'b1;
                    rx_valid_next     = 1'b1;
                end
            end
        end
    end

    // result of this transfer
    always_comb begin
        result_next               = '0;
        result_next.tx_line       = tx_level_next;
        result_next.tx_busy       = tx_active_next;
        result_next.send_accepted = accepted_next;
        result_next.rx_valid      = rx_valid_next;
        result_next.rx_byte       = rx_held_byte_next;
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= BIT_PERIOD_RESET;
        end else if (cfg_we) begin
            bit_period_reg <= cfg_wdata;
        end
    end

    // state advances on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_shift_reg      <= '1;
            tx_bits_left_reg  <= TX_FRAME_BITS;
            tx_tick_count_reg <= '0;
            tx_active_reg     <= 1'b0;
            tx_level_reg      <= 1'b1;
            tx_pending_reg    <= 1'b1;
            rx_hunting_reg    <= 1'b1;
            rx_tick_count_reg <= '0;
            rx_shift_reg      <= '0;
            rx_bits_left_reg  <= RX_DATA_BITS;
            rx_prev_level_reg <= 1'b1;
            rx_held_byte_reg  <= '0;
        end else if (in_fire) begin
            tx_shift_reg      <= tx_shift_next;
            tx_bits_left_reg  <= tx_bits_left_next;
            tx_tick_count_reg <= tx_tick_count_next;
            tx_active_reg     <= tx_active_next;
            tx_level_reg      <= tx_level_next;
            tx_pending_reg    <= tx_pending_next;
            rx_hunting_reg    <= rx_hunting_next;
            rx_tick_count_reg <= rx_tick_count_next;
            rx_shift_reg      <= rx_shift_next;
            rx_bits_left_reg  <= rx_bits_left_next;
            rx_prev_level_reg <= in_item.rx_line;
            rx_held_byte_reg  <= rx_held_byte_next;
        end
    end

    // output register with skid register behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_item_reg <= skid_item_reg;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_item_reg <= result_next;
            end else begin
                skid_item_reg <= result_next;
            end
        end
    end

    // skid register only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds data while output register is empty");

    // transmit bit count stays within a frame
    a_tx_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_bits_left_reg <= TX_FRAME_BITS)
        else $error("transmit bit count out of range");

    // an accepted send leaves the transmitter busy
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && accepted_next) |=> tx_active_reg)
        else $error("send accepted but transmitter not busy");

    // a completed byte returns the receiver to edge hunting
    a_rx_done_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && rx_valid_next) |=> (rx_hunting_reg && rx_bits_left_reg == RX_DATA_BITS))
        else $error("receiver not hunting after a completed byte");

    // idle transmitter drives mark
    a_tx_idle_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        !tx_active_reg |-> (tx_level_reg && tx_pending_reg))
        else $error("idle transmitter not at mark level");

endmodule

[test/testbench.sv]
// self-checking testbench for the timer based uart 8n1 transmitter and receiver
`timescale 1ns / 1ps

module testbench
    import tbuart_pkg::*;
();

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [PERIOD_W-1:0]  cfg_wdata     = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    timer_based_uart_tx_rx_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // line state predicted for every accepted tick, oldest first
    out_item_t line_state_q[$];

    // rx line levels still to be driven, one per tick
    bit line_plan[$];

    // predicted uart state
    logic [PERIOD_W-1:0] bit_period_m;
    logic [FRAME_W-1:0]  tx_frame;
    logic [BITS_W-1:0]   tx_left;
    logic [TX_CNT_W-1:0] tx_ticks;
    logic                tx_on;
    logic                tx_lvl;
    logic                tx_next;
    logic                rx_idle;
    logic [RX_CNT_W-1:0] rx_ticks;
    logic [BYTE_W-1:0]   rx_sh;
    logic [BITS_W-1:0]   rx_left;
    logic                rx_last_line;
    logic [BYTE_W-1:0]   rx_data;

    bit          steady      = 1'b0;
    int unsigned mismatches  = 0;
    int unsigned ticks_seen  = 0;
    int unsigned bytes_seen  = 0;
    int unsigned sends_seen  = 0;
    int unsigned settings    = 1;
    out_item_t   seen_item;
    out_item_t   want_item;

    task automatic init_uart_model();
        bit_period_m = BIT_PERIOD_RESET;
        tx_frame     = '1;
        tx_left      = TX_FRAME_BITS;
        tx_ticks     = '0;
        tx_on        = 1'b0;
        tx_lvl       = 1'b1;
        tx_next      = 1'b1;
        rx_idle      = 1'b1;
        rx_ticks     = '0;
        rx_sh        = '0;
        rx_left      = RX_DATA_BITS;
        rx_last_line = 1'b1;
        rx_data      = '0;
    endtask

    // advance the uart by one tick and return the line state after it
    function automatic out_item_t advance_uart(input logic line, input logic req,
                                               input logic [BYTE_W-1:0] data_b);
        out_item_t           res;
        logic [RX_CNT_W-1:0] span;
        logic [RX_CNT_W-1:0] goal;
        logic                took;
        logic                done;
        took = 1'b0;
        done = 1'b0;
        span = (bit_period_m == '0) ? RX_CNT_W'(1) : RX_CNT_W'(bit_period_m);

        // transmitter: request taken only when idle at the start of the tick
        if (tx_on) begin
            tx_ticks = tx_ticks + 1'b1;
            if (RX_CNT_W'(tx_ticks) >= span) begin
                tx_ticks = '0;
                tx_lvl   = tx_next;
                if (tx_left == '0) begin
                    tx_on   = 1'b0;
                    tx_left = TX_FRAME_BITS;
                end else begin
                    tx_next  = tx_frame[0];
                    tx_frame = {1'b1, tx_frame[FRAME_W-1:1]};
                    tx_left  = tx_left - 1'b1;
                end
            end
        end else if (req) begin
            tx_frame = {1'b1, data_b, 1'b0};
            tx_left  = TX_FRAME_BITS;
            tx_ticks = '0;
            tx_next  = 1'b1;
            tx_on    = 1'b1;
            took     = 1'b1;
        end

        // receiver: falling edge, then sample at 1.5 bits and every bit after
        if (rx_idle) begin
            if (rx_last_line && !line) begin
                rx_idle  = 1'b0;
                rx_ticks = '0;
                rx_left  = RX_DATA_BITS;
            end
        end else begin
            goal = (rx_left >= RX_DATA_BITS) ? span + (span >> 1) : span;
            rx_ticks = rx_ticks + 1'b1;
            if (rx_ticks >= goal) begin
                rx_ticks = '0;
                rx_sh    = {line, rx_sh[BYTE_W-1:1]};
                rx_left  = rx_left - 1'b1;
                if (rx_left == '0) begin
                    rx_data = rx_sh;
                    rx_left = RX_DATA_BITS;
                    rx_idle = 1'b1;
                    done    = 1'b1;
                end
            end
        end
        rx_last_line = line;

        res               = '0;
        res.tx_line       = tx_lvl;
        res.tx_busy       = tx_on;
        res.send_accepted = took;
        res.rx_valid      = done;
        res.rx_byte       = rx_data;
        return res;
    endfunction

    // one input transfer; entered and left just after a falling edge
    task automatic send_tick(input logic line, input logic req, input logic [BYTE_W-1:0] data_b);
        in_item_t item;
        item              = '0;
        item.rx_line      = line;
        item.send_request = req;
        item.send_byte    = data_b;
        if (!steady) begin
            while ($urandom_range(99) < 36) begin
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        line_state_q.push_back(advance_uart(line, req, data_b));
        @(negedge aclk);
    endtask

    // stop sending and wait until every predicted line state has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (line_state_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_bit_period(input logic [PERIOD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we       <= 1'b0;
        bit_period_m = value;
        settings++;
    endtask

    // queue rx line levels: mostly clean frames, some with a low stop bit, some noise
    function automatic void plan_rx_traffic(input int unsigned bt);
        int unsigned        pick;
        int unsigned        gap;
        int unsigned        i;
        int unsigned        j;
        logic [FRAME_W-1:0] frame;
        pick = $urandom_range(99);
        if (pick < 85) begin
            frame = {(pick < 70), BYTE_W'($urandom_range(255)), 1'b0};
            gap   = $urandom_range(2 * bt, 1);
            for (i = 0; i < gap; i++) line_plan.push_back(1'b1);
            for (i = 0; i < FRAME_W; i++)
                for (j = 0; j < bt; j++) line_plan.push_back(frame[i]);
        end else begin
            gap = $urandom_range(8, 1);
            for (i = 0; i < gap; i++) line_plan.push_back(1'($urandom_range(1)));
        end
    endfunction

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen_item = out_item_t'(m_axis_tdata);
            ticks_seen++;
            if (seen_item.rx_valid) bytes_seen++;
            if (seen_item.send_accepted) sends_seen++;
            if (line_state_q.size() == 0) begin
                $error("result transfer with no prediction waiting: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want_item = line_state_q.pop_front();
                if (seen_item.tx_line !== want_item.tx_line) begin
                    $error("tx_line: expected %0d, actual %0d",
                           want_item.tx_line, seen_item.tx_line);
                    mismatches++;
                end
                if (seen_item.tx_busy !== want_item.tx_busy) begin
                    $error("tx_busy: expected %0d, actual %0d",
                           want_item.tx_busy, seen_item.tx_busy);
                    mismatches++;
                end
                if (seen_item.send_accepted !== want_item.send_accepted) begin
                    $error("send_accepted: expected %0d, actual %0d",
                           want_item.send_accepted, seen_item.send_accepted);
                    mismatches++;
                end
                if (seen_item.rx_valid !== want_item.rx_valid) begin
                    $error("rx_valid: expected %0d, actual %0d",
                           want_item.rx_valid, seen_item.rx_valid);
                    mismatches++;
                end
                if (seen_item.rx_byte !== want_item.rx_byte) begin
                    $error("rx_byte: expected %h, actual %h",
                           want_item.rx_byte, seen_item.rx_byte);
                    mismatches++;
                end
                if (seen_item.pad !== want_item.pad) begin
                    $error("pad: expected %h, actual %h", want_item.pad, seen_item.pad);
                    mismatches++;
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 36);
    end

    // reset bit period: first request taken, busy ignores the next, rx edge starts a byte
    task automatic test_reset_period();
        send_tick(1'b1, 1'b1, 8'hFF);
        send_tick(1'b0, 1'b1, 8'h00);
        send_tick(1'b1, 1'b0, 8'h5A);
        send_tick(1'b1, 1'b1, 8'hA5);
    endtask

    // zero period acts as one tick per bit: a whole tx frame, a request on the tick
    // busy clears, and a falling edge on the last rx sample that must not start a byte
    task automatic test_min_period();
        logic [12:0] rx_pattern;
        int unsigned k;
        rx_pattern = 13'b1_1001_0101_0101;
        settle();
        set_bit_period('0);
        for (k = 0; k < 13; k++)
            send_tick(rx_pattern[k], 1'b1, (k == 12) ? 8'h81 : 8'h00);
    endtask

    // counters run far under the widest period, then a short period fires them at once
    task automatic test_period_change();
        int unsigned k;
        settle();
        set_bit_period(16'hFFFF);
        send_tick(1'b0, 1'b1, 8'hC3);
        for (k = 0; k < 5; k++) send_tick(1'b0, 1'b0, 8'h00);
        settle();
        set_bit_period(16'd4);
        for (k = 0; k < 4; k++) send_tick(1'b1, 1'b1, 8'h7E);
    endtask

    task automatic run_random_phase(input logic [PERIOD_W-1:0] period_v,
                                    input int unsigned count, input bit no_gaps);
        int unsigned bt;
        int unsigned k;
        settle();
        set_bit_period(period_v);
        steady = no_gaps;
        bt     = (period_v == '0) ? 1 : int'(period_v);
        line_plan.delete();
        for (k = 0; k < count; k++) begin
            if (line_plan.size() == 0) plan_rx_traffic(bt);
            send_tick(line_plan.pop_front(), 1'($urandom_range(1)),
                      BYTE_W'($urandom_range(255)));
        end
        steady = 1'b0;
    endtask

    // random frames and send requests over several bit periods
    task automatic test_random_traffic();
        run_random_phase(16'd4, 90, 1'b1);
        run_random_phase(16'd6, 80, 1'b0);
        run_random_phase(16'd9, 100, 1'b0);
        run_random_phase(16'd1, 60, 1'b0);
        run_random_phase(16'd0, 40, 1'b0);
        run_random_phase(16'd3, 80, 1'b0);
    endtask

    initial begin
        init_uart_model();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_period();
        test_min_period();
        test_period_change();
        test_random_traffic();
        settle();
        $display("checked %0d ticks over %0d bit period settings", ticks_seen, settings);
        $display("saw %0d received bytes and %0d accepted sends", bytes_seen, sends_seen);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", line_state_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
